// ===== rtl/mrwb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwb_pkg: shared types and constants of the max-RGB white balance block
// Channel, pixel and job types, command codes and the full-scale value.
// ----------------------------------------------------------------------------
package mrwb_pkg;

  // Width of one color channel and number of channels per pixel.
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NUM_CH = 3;

  // Full-scale channel value; also stands in for a zero channel maximum.
  localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

  // Channel order inside a pixel, from the lowest bits up.
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // Pass codes carried in the command field.
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] pixel_t;

  // One apply-pass pixel together with the divisors that were current
  // when it arrived.
  typedef struct packed {
    pixel_t value;
    pixel_t divisor;
  } job_t;

  // Write side of the job queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

// ===== rtl/max_rgb_white_balance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_rgb_white_balance: white-patch (max-RGB) white balance
// Two-pass stream processor: measure channel maxima, then scale pixels.
// ----------------------------------------------------------------------------
// Each frame is sent twice. Measure-pass pixels (tuser[0] low) update the
// running red, green and blue maxima and produce no output; tuser[1] high on
// a measure pixel restarts the maxima from that pixel. Apply-pass pixels
// (tuser[0] high) come out as channel*255/max per channel, truncated, with a
// zero maximum taken as 255 and results above 255 held at 255. A measure
// pixel is taken whenever the queue has room. An apply pixel occupies the
// shared divider for a load step and one step per quotient bit, eight bits,
// and the divider takes no new job before its result is in the output
// register; a queue of QUEUE_DEPTH jobs in front of the divider lets input
// and output stall independently, and a finished result waits there.
// ----------------------------------------------------------------------------
module max_rgb_white_balance #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic [1:0]  in_tuser,   // command [0], frame_start [1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red_out [7:0], green_out [15:8], blue_out [23:16]
);

  mrwb_pkg::pixel_t    in_pixel;
  mrwb_pkg::pixel_t    out_pixel;
  mrwb_pkg::job_push_t push;
  mrwb_pkg::job_t      pop_job;
  logic                queue_full;
  logic                pop_valid;
  logic                pop_ready;

  assign in_pixel  = mrwb_pkg::pixel_t'(in_tdata);
  assign out_tdata = 24'(out_pixel);

  // Front: classify pixels and keep the channel maxima.
  mrwb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .command    (in_tuser[0]),
    .frame_start(in_tuser[1]),
    .pixel      (in_pixel),
    .queue_full (queue_full),
    .push       (push)
  );

  // Queue of apply jobs.
  mrwb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (queue_full),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job)
  );

  // Back: serial division and output register.
  mrwb_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(pop_valid),
    .job_ready(pop_ready),
    .job      (pop_job),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pixel(out_pixel)
  );

endmodule

// ===== rtl/mrwb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwb_front: input stage of the white balance block
// Accepts pixels, tracks the per-channel maxima in the measure pass and
// queues apply-pass pixels with the divisors that hold at that moment.
// ----------------------------------------------------------------------------
module mrwb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic                frame_start,
  input  mrwb_pkg::pixel_t    pixel,
  input  logic                queue_full,
  output mrwb_pkg::job_push_t push
);

  mrwb_pkg::pixel_t peak_r;
  mrwb_pkg::pixel_t peak_nxt;
  logic             accept;

  // An item is taken whenever the queue has room for a possible apply job.
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Running maxima; a frame start restarts them from this pixel.
  always_comb begin
    peak_nxt = peak_r;
    if (accept && command == mrwb_pkg::CMD_MEASURE) begin
      for (int c = 0; c < mrwb_pkg::NUM_CH; c++) begin
        if (frame_start || pixel[c] > peak_r[c]) begin
          peak_nxt[c] = pixel[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

  // Apply pixels go to the queue; a zero maximum divides by full scale.
  always_comb begin
    push.valid     = accept && command == mrwb_pkg::CMD_APPLY;
    push.job.value = pixel;
    for (int c = 0; c < mrwb_pkg::NUM_CH; c++) begin
      push.job.divisor[c] = (peak_r[c] == '0) ? mrwb_pkg::FULL_SCALE : peak_r[c];
    end
  end

endmodule

// ===== rtl/mrwb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwb_queue: job queue between the input stage and the divider
// A small register FIFO that lets the two sides stall independently.
// ----------------------------------------------------------------------------
module mrwb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrwb_pkg::job_push_t push,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mrwb_pkg::job_t      pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mrwb_pkg::job_t   store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == FULL_CNT);
  assign pop_valid = (count_r != '0);
  assign pop_job   = store_r[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

// ===== rtl/mrwb_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwb_divider: scaling stage of the white balance block
// Computes channel*255/max for all three channels with a shared-schedule
// restoring divider, one quotient bit per cycle, and holds the result in
// an output register until it is taken; results above 255 are held at 255.
// ----------------------------------------------------------------------------
module mrwb_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  mrwb_pkg::job_t   job,
  output logic             out_valid,
  input  logic             out_ready,
  output mrwb_pkg::pixel_t out_pixel
);

  localparam int unsigned W     = mrwb_pkg::CH_W;
  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_HOLD
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  mrwb_pkg::pixel_t rem_r, rem_nxt;
  mrwb_pkg::pixel_t quo_r, quo_nxt;      // numerator bits shift out, quotient in
  mrwb_pkg::pixel_t div_r, div_nxt;
  logic [mrwb_pkg::NUM_CH-1:0] sat_r, sat_nxt;
  logic             out_valid_r, out_valid_nxt;
  mrwb_pkg::pixel_t out_pixel_r, out_pixel_nxt;

  mrwb_pkg::pixel_t rem_step;
  mrwb_pkg::pixel_t quo_step;
  logic             out_free;

  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_free  = !out_valid_r || out_ready;

  // One restoring step per channel: bring in a numerator bit, subtract if it fits.
  always_comb begin
    logic [W:0] trial;
    trial = '0;
    for (int c = 0; c < mrwb_pkg::NUM_CH; c++) begin
      trial = {rem_r[c], quo_r[c][W-1]};
      if (trial >= {1'b0, div_r[c]}) begin
        rem_step[c] = W'(trial - {1'b0, div_r[c]});
        quo_step[c] = {quo_r[c][W-2:0], 1'b1};
      end else begin
        rem_step[c] = W'(trial);
        quo_step[c] = {quo_r[c][W-2:0], 1'b0};
      end
    end
  end

  // Sequencer: load a job, run one step per bit, then deliver the result.
  always_comb begin
    logic [2*W-1:0] numer;
    numer         = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_nxt       = div_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          for (int c = 0; c < mrwb_pkg::NUM_CH; c++) begin
            // value*255 as (value << 8) - value; its upper byte is below the
            // divisor whenever the quotient fits in one channel.
            numer      = {job.value[c], {W{1'b0}}} - {{W{1'b0}}, job.value[c]};
            rem_nxt[c] = numer[2*W-1:W];
            quo_nxt[c] = numer[W-1:0];
            div_nxt[c] = job.divisor[c];
            sat_nxt[c] = (job.value[c] >= job.divisor[c]);
          end
          step_nxt  = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          if (out_free) begin
            for (int c = 0; c < mrwb_pkg::NUM_CH; c++) begin
              out_pixel_nxt[c] = sat_r[c] ? mrwb_pkg::FULL_SCALE : quo_step[c];
            end
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          for (int c = 0; c < mrwb_pkg::NUM_CH; c++) begin
            out_pixel_nxt[c] = sat_r[c] ? mrwb_pkg::FULL_SCALE : quo_r[c];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    div_r       <= div_nxt;
    sat_r       <= sat_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

endmodule

// ===== rtl/mrwb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwb_checker: port-level checks for the white balance block
// Tracks apply transactions still owed a result and checks output behavior.
// ----------------------------------------------------------------------------
module mrwb_checker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Queue entries plus the divider plus the output register.
  localparam int unsigned MAX_PENDING = QUEUE_DEPTH + 2;
  localparam int unsigned PEND_W      = $clog2(MAX_PENDING + 2);

  logic [PEND_W-1:0] pending_r;
  logic              in_apply;
  logic              out_xfer;

  assign in_apply = in_tvalid && in_tready && in_tuser[0] == mrwb_pkg::CMD_APPLY;
  assign out_xfer = out_tvalid && out_tready;

  // Count of apply transactions whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_apply && !out_xfer) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_xfer && !in_apply && pending_r != '0) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // Every output transaction answers an earlier apply transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != '0)
    else $error("output without a pending apply pixel");

  // Outstanding work never exceeds the storage of the design.
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PEND_W'(MAX_PENDING))
    else $error("more apply pixels accepted than can be held");

  // Measure pixels alone never raise the output.
  a_measure_silent: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == '0 && !in_apply |=> !out_tvalid)
    else $error("output raised by a measure pixel");

endmodule

bind max_rgb_white_balance mrwb_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_mrwb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== test/tb_max_rgb_white_balance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_rgb_white_balance: self-checking bench for the max-RGB white balance
// Short directed frames, then about 700 random pixels, mostly well-formed
// measure/apply frame pairs with random content and some scrambled items.
// Both stream sides idle at random. One long output hold-off fills the block.
// A built-in model tracks the channel peaks and predicts each balanced pixel,
// which is checked field by field against the output stream in order.
// ----------------------------------------------------------------------------
module tb_max_rgb_white_balance;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned IDLE_PCT     = 35;
  // No idling on either side while the count of accepted pixels lies in this range.
  localparam int unsigned QUIET_LO     = 350;
  localparam int unsigned QUIET_HI     = 500;
  // The output side stops for a long stretch once this many pixels are in.
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 60;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    logic             cmd;
    logic             sof;
    mrwb_pkg::pixel_t px;
    logic             drain;  // wait until all balanced pixels are out before offering
  } pixel_req_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // red_in [7:0], green_in [15:8], blue_in [23:16]
  logic [1:0]  in_tuser   = '0;   // command [0], frame_start [1]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // red_out [7:0], green_out [15:8], blue_out [23:16]

  pixel_req_t       pending_pixels[$];
  mrwb_pkg::pixel_t expected_balanced[$];
  mrwb_pkg::pixel_t held_peak;
  logic             in_taken;
  int unsigned      pixels_in;
  int unsigned      error_count;
  int unsigned      cycle_count;
  int unsigned      hold_left;
  logic             hold_done;
  string            chan_label[mrwb_pkg::NUM_CH] = '{"red", "green", "blue"};

  max_rgb_white_balance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Free-running clock.
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // One channel scaled to full scale by its peak, a zero peak taken as
  // full scale and anything above full scale held there.
  function automatic mrwb_pkg::chan_t balance_channel(mrwb_pkg::chan_t level,
                                                      mrwb_pkg::chan_t peak);
    logic [15:0] divisor;
    logic [15:0] scaled;
    divisor = (peak == '0) ? 16'(mrwb_pkg::FULL_SCALE) : 16'(peak);
    scaled  = (16'(level) * 16'(mrwb_pkg::FULL_SCALE)) / divisor;
    return (scaled > 16'(mrwb_pkg::FULL_SCALE)) ? mrwb_pkg::FULL_SCALE
                                                : scaled[mrwb_pkg::CH_W-1:0];
  endfunction

  task automatic queue_pixel(logic cmd, logic sof, mrwb_pkg::chan_t r,
                             mrwb_pkg::chan_t g, mrwb_pkg::chan_t b);
    pixel_req_t req;
    req.cmd                    = cmd;
    req.sof                    = sof;
    req.px[mrwb_pkg::CH_RED]   = r;
    req.px[mrwb_pkg::CH_GREEN] = g;
    req.px[mrwb_pkg::CH_BLUE]  = b;
    req.drain                  = 1'b0;
    pending_pixels.push_back(req);
  endtask

  // Pixel source: offers the next pending pixel at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_pixels.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_pixels[0].drain && expected_balanced.size() != 0) begin
        in_tvalid <= 1'b0;
      end else if (!(pixels_in >= QUIET_LO && pixels_in < QUIET_HI) &&
                   $urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_pixels[0].px;
        in_tuser  <= {pending_pixels[0].sof, pending_pixels[0].cmd};
        void'(pending_pixels.pop_front());
      end
    end
  end

  // Pixel sink: random back-pressure plus one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && pixels_in >= HOLD_AT) begin
      hold_done  = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (pixels_in >= QUIET_LO && pixels_in < QUIET_HI) ||
                    ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: checks each output transaction, then tracks each input
  // transaction through the peak model.
  always @(posedge clk) begin : monitor_p
    mrwb_pkg::pixel_t got;
    mrwb_pkg::pixel_t want;
    mrwb_pkg::pixel_t px;
    mrwb_pkg::pixel_t balanced;
    if (!rst_n) begin
      in_taken    = 1'b0;
      pixels_in   = 0;
      held_peak   = '0;
    end else begin
      // Output side first, so a result is never matched to a pixel taken
      // at the same edge.
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_balanced.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, actual %h",
                   $time, got);
          error_count++;
        end else begin
          want = expected_balanced.pop_front();
          for (int ch = 0; ch < mrwb_pkg::NUM_CH; ch++) begin
            if (got[ch] !== want[ch]) begin
              $display("%0t: %s_out mismatch, expected %0d, actual %0d",
                       $time, chan_label[ch], want[ch], got[ch]);
              error_count++;
            end
          end
        end
      end

      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        pixels_in++;
        px = in_tdata;
        if (in_tuser[0] == mrwb_pkg::CMD_MEASURE) begin
          if (in_tuser[1]) held_peak = '0;
          for (int ch = 0; ch < mrwb_pkg::NUM_CH; ch++) begin
            if (px[ch] > held_peak[ch]) held_peak[ch] = px[ch];
          end
        end else begin
          for (int ch = 0; ch < mrwb_pkg::NUM_CH; ch++) begin
            balanced[ch] = balance_channel(px[ch], held_peak[ch]);
          end
          expected_balanced.push_back(balanced);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus_p
    int unsigned      first_random;
    int unsigned      queued;
    int unsigned      frame_len;
    int unsigned      pick;
    mrwb_pkg::chan_t  ceil_r;
    mrwb_pkg::chan_t  ceil_g;
    mrwb_pkg::chan_t  ceil_b;
    mrwb_pkg::pixel_t frame_px[$];
    mrwb_pkg::pixel_t p;

    error_count = 0;
    cycle_count = 0;

    // Apply before any measure: reset peaks, pixels pass through unchanged.
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd0,   8'd128, 8'd255);
    // Frame start on an apply pixel is ignored.
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b1, 8'd1,   8'd254, 8'd77);
    // Small frame with a zero green peak.
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b1, 8'd10,  8'd0,   8'd255);
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b0, 8'd20,  8'd0,   8'd100);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd20,  8'd0,   8'd255);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd10,  8'd77,  8'd128);
    // Pixel above its frame's peak saturates.
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd255, 8'd255, 8'd0);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b1, 8'd0,   8'd1,   8'd254);
    // Full-scale peaks.
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b1, 8'd255, 8'd255, 8'd255);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd255, 8'd0,   8'd1);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd128, 8'd254, 8'd170);
    // Peaks of one: everything non-zero saturates.
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b1, 8'd1,   8'd1,   8'd1);
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b0, 8'd0,   8'd0,   8'd0);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd1,   8'd0,   8'd255);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd2,   8'd1,   8'd0);
    // All-zero frame: every peak stands in as full scale.
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b1, 8'd0,   8'd0,   8'd0);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd255, 8'd85,  8'd3);
    // Continuing a frame without frame start raises the peaks further.
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b1, 8'd3,   8'd200, 8'd7);
    queue_pixel(mrwb_pkg::CMD_MEASURE, 1'b0, 8'd170, 8'd100, 8'd7);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd3,   8'd199, 8'd6);
    queue_pixel(mrwb_pkg::CMD_APPLY,   1'b0, 8'd171, 8'd200, 8'd8);

    // Random part: mostly measure/apply frame pairs, some scrambled items.
    first_random = pending_pixels.size();
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // Noise: a short burst of fully random items.
        repeat ($urandom_range(4, 1)) begin
          queue_pixel(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
          queued++;
        end
      end else begin
        frame_len = ($urandom_range(19) == 0) ? $urandom_range(16, 7)
                                              : $urandom_range(6, 1);
        // Per-channel ceilings give a spread of peak sizes, zero included.
        case ($urandom_range(3))
          0: begin
            ceil_r = 8'd255; ceil_g = 8'd255; ceil_b = 8'd255;
          end
          1: begin
            ceil_r = 8'($urandom_range(15)); ceil_g = 8'($urandom_range(15));
            ceil_b = 8'($urandom_range(15));
          end
          2: begin
            ceil_r = 8'($urandom); ceil_g = 8'($urandom); ceil_b = 8'($urandom);
          end
          default: begin
            ceil_r = ($urandom_range(1)) ? 8'd0 : 8'd255;
            ceil_g = ($urandom_range(1)) ? 8'd0 : 8'($urandom);
            ceil_b = ($urandom_range(1)) ? 8'd0 : 8'($urandom_range(3));
          end
        endcase
        frame_px.delete();
        for (int i = 0; i < frame_len; i++) begin
          p[mrwb_pkg::CH_RED]   = 8'($urandom_range(ceil_r));
          p[mrwb_pkg::CH_GREEN] = 8'($urandom_range(ceil_g));
          p[mrwb_pkg::CH_BLUE]  = 8'($urandom_range(ceil_b));
          frame_px.push_back(p);
          // An occasional missing frame start carries old peaks over.
          queue_pixel(mrwb_pkg::CMD_MEASURE,
                      (i == 0) ? ($urandom_range(9) != 0) : 1'b0,
                      p[mrwb_pkg::CH_RED], p[mrwb_pkg::CH_GREEN],
                      p[mrwb_pkg::CH_BLUE]);
        end
        for (int i = 0; i < frame_len; i++) begin
          p = frame_px[i];
          // Some apply pixels differ from the measured ones, so some exceed
          // the peaks and saturate.
          if ($urandom_range(7) == 0) p = 24'($urandom);
          queue_pixel(mrwb_pkg::CMD_APPLY, ($urandom_range(3) == 0),
                      p[mrwb_pkg::CH_RED], p[mrwb_pkg::CH_GREEN],
                      p[mrwb_pkg::CH_BLUE]);
        end
        queued += 2 * frame_len;
      end
    end

    // The sender waits for the output to run empty at these points.
    pending_pixels[first_random].drain = 1'b1;
    pending_pixels[first_random + pending_pixels.size() / 2].drain = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_pixels.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_balanced.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== max_rgb_white_balance.f =====
rtl/mrwb_pkg.sv
rtl/mrwb_front.sv
rtl/mrwb_queue.sv
rtl/mrwb_divider.sv
rtl/max_rgb_white_balance.sv
rtl/mrwb_checker.sv
test/tb_max_rgb_white_balance.sv
